FILE: rtl/core/ppr_pkg.sv
package ppr_pkg;

  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_ROT_W    = 3'd4,
    REG_ROT_X    = 3'd5,
    REG_ROT_Y    = 3'd6,
    REG_ROT_Z    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] offset;
    logic signed [31:0] qw;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
  } rot_mat_t;

  localparam logic signed [63:0] OneQ30 = 64'sd1073741824;
  localparam logic signed [63:0] DLimit = 64'sd8589934591;
  localparam logic signed [63:0] Int32Min = -64'sd2147483648;
  localparam logic signed [63:0] Int32Max = 64'sd2147483647;

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Round half up, then arithmetic shift right.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic signed [63:0] bias;
    bias = 64'sd1 <<< (s - 1);
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = clamp64(v, Int32Min, Int32Max);
    return c[31:0];
  endfunction

  function automatic logic signed [31:0] coef64(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = clamp64(v, -OneQ30, OneQ30);
    return c[31:0];
  endfunction

  function automatic logic signed [31:0] coef32(input logic signed [31:0] v);
    logic signed [63:0] c;
    c = clamp64(64'(v), -OneQ30, OneQ30);
    return c[31:0];
  endfunction

endpackage

FILE: rtl/core/ppr_cfg_regs.sv
module ppr_cfg_regs
  import ppr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic signed [31:0]        cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nx     <= '0;
      cfg.ny     <= '0;
      cfg.nz     <= OneQ30[31:0];
      cfg.offset <= '0;
      cfg.qw     <= OneQ30[31:0];
      cfg.qx     <= '0;
      cfg.qy     <= '0;
      cfg.qz     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NORMAL_X: cfg.nx     <= coef32(cfg_data);
        REG_NORMAL_Y: cfg.ny     <= coef32(cfg_data);
        REG_NORMAL_Z: cfg.nz     <= coef32(cfg_data);
        REG_OFFSET:   cfg.offset <= cfg_data;
        REG_ROT_W:    cfg.qw     <= coef32(cfg_data);
        REG_ROT_X:    cfg.qx     <= coef32(cfg_data);
        REG_ROT_Y:    cfg.qy     <= coef32(cfg_data);
        REG_ROT_Z:    cfg.qz     <= coef32(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/ppr_proj.sv
module ppr_proj
  import ppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  cfg_t               cfg,
  output logic               q_valid,
  output logic signed [31:0] q_x,
  output logic signed [31:0] q_y,
  output logic signed [31:0] q_z
);

  logic [4:1] v;
  logic signed [31:0] px_d [1:4];
  logic signed [31:0] py_d [1:4];
  logic signed [31:0] pz_d [1:4];
  logic signed [63:0] m_x, m_y, m_z;
  logic signed [63:0] dot;
  logic signed [33:0] distance;
  logic signed [63:0] dn_x, dn_y, dn_z;
  logic signed [63:0] distance_next;

  assign distance_next = clamp64(rnd_shr(dot, 30) - 64'(cfg.offset), -DLimit, DLimit);

  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      q_valid <= 1'b0;
    end else if (en) begin
      v       <= {v[3:1], in_valid};
      q_valid <= v[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_d[1] <= point_x;
      py_d[1] <= point_y;
      pz_d[1] <= point_z;
      for (int i = 2; i <= 4; i++) begin
        px_d[i] <= px_d[i-1];
        py_d[i] <= py_d[i-1];
        pz_d[i] <= pz_d[i-1];
      end
      m_x      <= point_x * cfg.nx;
      m_y      <= point_y * cfg.ny;
      m_z      <= point_z * cfg.nz;
      dot      <= m_x + m_y + m_z;
      distance <= distance_next[33:0];
      dn_x     <= distance * cfg.nx;
      dn_y     <= distance * cfg.ny;
      dn_z     <= distance * cfg.nz;
      q_x      <= sat32(64'(px_d[4]) - rnd_shr(dn_x, 30));
      q_y      <= sat32(64'(py_d[4]) - rnd_shr(dn_y, 30));
      q_z      <= sat32(64'(pz_d[4]) - rnd_shr(dn_z, 30));
    end
  end

endmodule

FILE: rtl/core/ppr_rot_mat.sv
module ppr_rot_mat
  import ppr_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  cfg_t     cfg,
  output rot_mat_t mat
);

  logic signed [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [63:0] s00, s01, s02, s10, s11, s12;
  rot_mat_t mat_d [3:4];

  // The matrix is rebuilt alongside each point, so it lines up with the
  // projected point at the fifth stage.
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= cfg.qx * cfg.qx;
      yy <= cfg.qy * cfg.qy;
      zz <= cfg.qz * cfg.qz;
      xy <= cfg.qx * cfg.qy;
      xz <= cfg.qx * cfg.qz;
      yz <= cfg.qy * cfg.qz;
      wx <= cfg.qw * cfg.qx;
      wy <= cfg.qw * cfg.qy;
      wz <= cfg.qw * cfg.qz;
      s00 <= yy + zz;
      s01 <= xy - wz;
      s02 <= xz + wy;
      s10 <= xy + wz;
      s11 <= xx + zz;
      s12 <= yz - wx;
      mat_d[3].r00 <= coef64(OneQ30 - rnd_shr(s00, 29));
      mat_d[3].r01 <= coef64(rnd_shr(s01, 29));
      mat_d[3].r02 <= coef64(rnd_shr(s02, 29));
      mat_d[3].r10 <= coef64(rnd_shr(s10, 29));
      mat_d[3].r11 <= coef64(OneQ30 - rnd_shr(s11, 29));
      mat_d[3].r12 <= coef64(rnd_shr(s12, 29));
      mat_d[4] <= mat_d[3];
      mat      <= mat_d[4];
    end
  end

endmodule

FILE: rtl/core/ppr_flat.sv
module ppr_flat
  import ppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               q_valid,
  input  logic signed [31:0] q_x,
  input  logic signed [31:0] q_y,
  input  logic signed [31:0] q_z,
  input  rot_mat_t           mat,
  output logic               out_valid,
  output logic signed [31:0] proj_x,
  output logic signed [31:0] proj_y,
  output logic signed [31:0] proj_z,
  output logic signed [31:0] flat_x,
  output logic signed [31:0] flat_y
);

  logic               v6;
  logic signed [31:0] qx6, qy6, qz6;
  logic signed [63:0] p00, p01, p02, p10, p11, p12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v6        <= q_valid;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx6 <= q_x;
      qy6 <= q_y;
      qz6 <= q_z;
      p00 <= mat.r00 * q_x;
      p01 <= mat.r01 * q_y;
      p02 <= mat.r02 * q_z;
      p10 <= mat.r10 * q_x;
      p11 <= mat.r11 * q_y;
      p12 <= mat.r12 * q_z;
      proj_x <= qx6;
      proj_y <= qy6;
      proj_z <= qz6;
      flat_x <= sat32(rnd_shr(p00 + p01 + p02, 30));
      flat_y <= sat32(rnd_shr(p10 + p11 + p12, 30));
    end
  end

endmodule

FILE: rtl/core/point_plane_project_rotate.sv
// Throughput: one point per cycle; the seven-stage pipeline advances as a whole and
// holds every stage while a finished result waits for out_ready.
// Reset (rst, synchronous, active high) empties the pipeline and loads the default
// plane (normal +Z, offset 0) and the identity rotation.
module point_plane_project_rotate
  import ppr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic signed [31:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] proj_x,
  output logic signed [31:0] proj_y,
  output logic signed [31:0] proj_z,
  output logic signed [31:0] flat_x,
  output logic signed [31:0] flat_y
);

  cfg_t               cfg;
  rot_mat_t           mat;
  logic               en;
  logic               q_valid;
  logic signed [31:0] q_x, q_y, q_z;

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  ppr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppr_proj u_proj (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_z      (q_z)
  );

  ppr_rot_mat u_mat (
    .clk (clk),
    .en  (en),
    .cfg (cfg),
    .mat (mat)
  );

  ppr_flat u_flat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .q_valid   (q_valid),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_z       (q_z),
    .mat       (mat),
    .out_valid (out_valid),
    .proj_x    (proj_x),
    .proj_y    (proj_y),
    .proj_z    (proj_z),
    .flat_x    (flat_x),
    .flat_y    (flat_y)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the output is stalled");

  a_empty_output_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while the output register is empty");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(flat_x) && $stable(proj_z))
    else $error("stalled result changed");

endmodule
